/* hw/rtl/wfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint follow stepper package
// Shared types, register indexes and constants of the waypoint stepper.
// ----------------------------------------------------------------------------
package wfs_pkg;

	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_STEP = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPEED = 3'd1;
	localparam logic [IDX_W-1:0] REG_CAPTURE = 3'd2;
	localparam logic [IDX_W-1:0] REG_STOP = 3'd3;
	localparam logic [IDX_W-1:0] REG_START_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_START_Z = 3'd6;

	localparam logic [23:0] STEP_RST = 24'd2621;
	localparam logic [23:0] SPEED_RST = 24'd52429;
	localparam logic [23:0] CAPTURE_RST = 24'd5243;
	localparam logic STOP_RST = 1'b1;
	localparam logic signed [31:0] START_X_RST = 32'sd0;
	localparam logic signed [31:0] START_Y_RST = 32'sd0;
	localparam logic signed [31:0] START_Z_RST = 32'sd78643;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_EMERGENCY = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS = 33;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] waypoint_x;
		logic signed [31:0] waypoint_y;
		logic signed [31:0] waypoint_z;
		logic first_waypoint;
		logic emergency_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [23:0] reported_speed;
		logic [8:0] current_target;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_DIFF,
		ST_SQUARE,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_DECIDE,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic diff;
		logic sq;
		logic sq_first;
		logic sqrt_init;
		logic sqrt_step;
		logic next_target;
		logic mul;
		logic div_init;
		logic div_step;
		logic upd;
		logic out_load;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic more;
		logic reached;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/waypoint_follow_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint follow stepper
// Moves a 3D position toward a list of waypoints by a bounded step per tick.
// ----------------------------------------------------------------------------
// Load and emergency beats are accepted while idle and give no result.
// A tick skips each waypoint already within the capture radius (33-step square
// root per waypoint), then, if one is left, moves toward it axis by axis; its
// result is held back while an earlier result is stalled.
// The input is free again in the cycle the result appears; one beat at a time.
// Reset restores the settings, empties the list and puts the position at start.
module waypoint_follow_stepper #(
	parameter int MAX_WAYPOINTS = wfs_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  wfs_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output wfs_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [wfs_pkg::IDX_W-1:0] cfg_index,
	input  logic [wfs_pkg::CFG_W-1:0] cfg_data
);
	import wfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wfs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	wfs_datapath #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);
endmodule

/* hw/rtl/wfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module wfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/wfs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint stepper datapath
// Holds position, waypoint list and settings, and runs the squares, the
// bit-serial square root and the bit-serial divisions under controller command.
// ----------------------------------------------------------------------------
module wfs_datapath #(
	parameter int MAX_WAYPOINTS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  wfs_pkg::cmd_t cmd,
	output wfs_pkg::sts_t sts,
	input  wfs_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output wfs_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [wfs_pkg::IDX_W-1:0] cfg_index,
	input  logic [wfs_pkg::CFG_W-1:0] cfg_data
);
	import wfs_pkg::*;

	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	logic [23:0] step_q, speed_q, cap_q;
	logic soe_q, emerg_q;
	logic signed [31:0] cur_q [3];
	logic [CW-1:0] count_q, target_q, base;
	logic ram_we;
	logic [95:0] rdata;
	logic [32:0] mag_q [3];
	logic neg_q [3];
	logic [32:0] mag_sel;
	logic [65:0] prod_q, acc_q, rad_q;
	logic [34:0] rem_q;
	logic [32:0] root_q;
	logic [36:0] rem_t, trial;
	logic [23:0] step_eff;
	logic [56:0] mp_q;
	logic [33:0] drem_q, dtry;
	logic [32:0] dq_q;
	logic signed [32:0] way_e [3];
	logic signed [31:0] cur_sel;
	logic neg_sel;
	logic [31:0] delta;
	logic frozen;

	assign frozen = emerg_q & soe_q;
	assign base = in_data.first_waypoint ? '0 : count_q;
	assign ram_we = cmd.accept && (in_data.operation == OP_LOAD)
		&& (base < CW'(MAX_WAYPOINTS));

	wfs_ram #(.WIDTH(96), .DEPTH(MAX_WAYPOINTS)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(base[AW-1:0]),
		.wdata({in_data.waypoint_x, in_data.waypoint_y, in_data.waypoint_z}),
		.raddr(target_q[AW-1:0]),
		.rdata(rdata)
	);

	assign way_e[0] = {rdata[95], rdata[95:64]};
	assign way_e[1] = {rdata[63], rdata[63:32]};
	assign way_e[2] = {rdata[31], rdata[31:0]};

	always_comb begin
		case (cmd.axis)
			2'd0: begin
				mag_sel = mag_q[0];
				cur_sel = cur_q[0];
				neg_sel = neg_q[0];
			end
			2'd1: begin
				mag_sel = mag_q[1];
				cur_sel = cur_q[1];
				neg_sel = neg_q[1];
			end
			default: begin
				mag_sel = mag_q[2];
				cur_sel = cur_q[2];
				neg_sel = neg_q[2];
			end
		endcase
	end

	assign rem_t = {rem_q, rad_q[65:64]};
	assign trial = {2'b00, root_q, 2'b01};
	assign step_eff = ({9'd0, step_q} < root_q) ? step_q : root_q[23:0];
	assign dtry = {drem_q[32:0], dq_q[32]};
	assign delta = neg_sel ? (32'd0 - dq_q[31:0]) : dq_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [32:0] d;
				d = way_e[i] - {cur_q[i][31], cur_q[i]};
				neg_q[i] <= d[32];
				mag_q[i] <= d[32] ? (33'd0 - d) : d;
			end
		end
		if (cmd.sq) begin
			prod_q <= mag_sel * mag_sel;
			acc_q <= cmd.sq_first ? '0 : acc_q + prod_q;
		end
		if (cmd.sqrt_init) begin
			rad_q <= acc_q;
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[63:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q <= 35'(rem_t - trial);
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				rem_q <= rem_t[34:0];
				root_q <= {root_q[31:0], 1'b0};
			end
		end
		if (cmd.mul) begin
			mp_q <= mag_sel * step_eff;
		end
		if (cmd.div_init) begin
			drem_q <= {10'd0, mp_q[56:33]};
			dq_q <= mp_q[32:0];
		end else if (cmd.div_step) begin
			if (dtry >= {1'b0, root_q}) begin
				drem_q <= dtry - {1'b0, root_q};
				dq_q <= {dq_q[31:0], 1'b1};
			end else begin
				drem_q <= dtry;
				dq_q <= {dq_q[31:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_data.pos_x <= cur_q[0];
			out_data.pos_y <= cur_q[1];
			out_data.pos_z <= cur_q[2];
			out_data.reported_speed <= frozen ? 24'd0 : speed_q;
			out_data.current_target <= 9'(target_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			speed_q <= SPEED_RST;
			cap_q <= CAPTURE_RST;
			soe_q <= STOP_RST;
			emerg_q <= 1'b0;
			cur_q[0] <= START_X_RST;
			cur_q[1] <= START_Y_RST;
			cur_q[2] <= START_Z_RST;
			count_q <= '0;
			target_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP: step_q <= cfg_data[23:0];
					REG_SPEED: speed_q <= cfg_data[23:0];
					REG_CAPTURE: cap_q <= cfg_data[23:0];
					REG_STOP: soe_q <= cfg_data[0];
					REG_START_X: cur_q[0] <= cfg_data;
					REG_START_Y: cur_q[1] <= cfg_data;
					REG_START_Z: cur_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept && in_data.operation == OP_LOAD) begin
				if (in_data.first_waypoint) begin
					target_q <= '0;
				end
				count_q <= ram_we ? CW'(base + 1'b1) : base;
			end
			if (cmd.accept && in_data.operation == OP_EMERGENCY) begin
				emerg_q <= in_data.emergency_value;
			end
			if (cmd.next_target) begin
				target_q <= CW'(target_q + 1'b1);
			end
			if (cmd.upd) begin
				case (cmd.axis)
					2'd0: cur_q[0] <= cur_sel + delta;
					2'd1: cur_q[1] <= cur_sel + delta;
					default: cur_q[2] <= cur_sel + delta;
				endcase
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.tick = (in_data.operation == OP_TICK);
	assign sts.more = !frozen && (target_q < count_q);
	assign sts.reached = (root_q <= {9'd0, cap_q});
	assign sts.out_free = !out_valid || !out_stall;
endmodule

/* hw/rtl/wfs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint stepper controller
// Sequences one tick: waypoint skipping, distance, and the per-axis move.
// ----------------------------------------------------------------------------
module wfs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  wfs_pkg::sts_t sts,
	output wfs_pkg::cmd_t cmd
);
	import wfs_pkg::*;

	state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.tick) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = sts.more ? ST_READ : ST_DONE;
			ST_READ: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (cnt_q == 6'd3) state_d = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == 6'(SQRT_STEPS - 1)) state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = sts.reached ? ST_CHECK : ST_MUL;
			ST_MUL: state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = (axis_q == 2'd2) ? ST_DONE : ST_MUL;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.axis = (state_q == ST_SQUARE) ? cnt_q[1:0] : axis_q;
		case (state_q)
			ST_IDLE: cmd.accept = in_valid;
			ST_READ: cmd.rd = 1'b1;
			ST_DIFF: cmd.diff = 1'b1;
			ST_SQUARE: begin
				cmd.sq = 1'b1;
				cmd.sq_first = (cnt_q == 6'd0);
			end
			ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_DECIDE: cmd.next_target = sts.reached;
			ST_MUL: cmd.mul = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_UPDATE: cmd.upd = 1'b1;
			ST_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			axis_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 6'd0 : 6'(cnt_q + 1'b1);
			if (state_q == ST_DECIDE) begin
				axis_q <= 2'd0;
			end else if (state_q == ST_UPDATE) begin
				axis_q <= 2'(axis_q + 1'b1);
			end
		end
	end
endmodule
